/* src/assert_macros.svh */
// Assertion macros shared by the list design.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define OLHT_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Expression must never be true outside reset.
`define OLHT_ASSERT_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

/* src/olht_pkg.sv */
// Shared constants, codes and the cell control type of the ordered list.
package olht_pkg;

   localparam int DATA_W = 32;
   localparam int CMD_W = 2;
   localparam int STAT_W = 2;
   localparam int POS_W = 5;
   localparam int CNT_W = 6;
   localparam int MAX_OUT = 32;
   localparam int DEFAULT_CAPACITY = 32;

   // Command codes.
   localparam logic [CMD_W-1:0] CMD_FRONT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_BACK = 2'd1;
   localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;
   localparam logic [CMD_W-1:0] CMD_LIST = 2'd3;

   // Status codes.
   localparam logic [STAT_W-1:0] ST_DONE = 2'd0;
   localparam logic [STAT_W-1:0] ST_FULL = 2'd1;
   localparam logic [STAT_W-1:0] ST_BADIDX = 2'd2;

   // Control broadcast to every cell of the chain.
   typedef struct packed {
      logic push_front;
      logic push_back;
      logic pull;
      logic rotate;
      logic [CNT_W-1:0] count;
      logic [POS_W-1:0] index;
   } ctl_type;

endpackage

/* src/ordered_list_head_tail_insert_delete.sv */
// Latency: the command is applied at the accepting edge; results follow from the next cycle.
// Each command yields max(n,1) result words, n the list length after it; no new command is taken while busy.
// The list is read out by rotating the cell chain one place per cycle, the head cell giving each word.
// Results cannot be stalled; the strobe rsp_valid marks each one for a single cycle.
// Synchronous reset empties the list and clears control state; cell contents are not reset.
`include "assert_macros.svh"

module ordered_list_head_tail_insert_delete #(
   parameter int CAPACITY = olht_pkg::DEFAULT_CAPACITY
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  logic [olht_pkg::CMD_W-1:0] req_cmd,
   input  logic signed [olht_pkg::DATA_W-1:0] req_value,
   output logic rsp_valid,
   output logic signed [olht_pkg::DATA_W-1:0] rsp_element,
   output logic [olht_pkg::POS_W-1:0] rsp_position,
   output logic rsp_list_empty,
   output logic [olht_pkg::STAT_W-1:0] rsp_status,
   output logic rsp_last
);
   import olht_pkg::*;

   localparam int EFF_CAP = (CAPACITY < MAX_OUT) ? CAPACITY : MAX_OUT;
   localparam logic [CNT_W-1:0] CAP_COUNT = CNT_W'(EFF_CAP);

   logic busy_ff, busy_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [STAT_W-1:0] status_ff, status_in;

   logic accept;
   logic full;
   logic index_ok;
   logic list_none;
   logic at_end;
   ctl_type ctl;
   logic [DATA_W-1:0] cell_values [EFF_CAP];

   assign accept = start && !busy_ff;
   assign full = (count_ff >= CAP_COUNT);
   assign index_ok = (req_value < {{(DATA_W-CNT_W){1'b0}}, count_ff});
   assign list_none = (count_ff == '0);
   assign at_end = list_none || (({1'b0, pos_ff} + CNT_W'(1)) == count_ff);

   // Command decode and the control word broadcast to the chain.
   always_comb begin
      ctl.push_front = accept && (req_cmd == CMD_FRONT) && !full;
      ctl.push_back = accept && (req_cmd == CMD_BACK) && !full;
      ctl.pull = accept && (req_cmd == CMD_DELETE) && index_ok;
      ctl.rotate = busy_ff && !list_none;
      ctl.count = count_ff;
      ctl.index = req_value[POS_W-1:0];
   end

   // Count, status, read-out position and busy flag.
   always_comb begin
      count_in = count_ff;
      status_in = status_ff;
      pos_in = pos_ff;
      busy_in = busy_ff;
      if (accept) begin
         busy_in = 1'b1;
         pos_in = '0;
         unique case (req_cmd) inside
            CMD_FRONT, CMD_BACK: begin
               status_in = full ? ST_FULL : ST_DONE;
            end
            CMD_DELETE: begin
               status_in = index_ok ? ST_DONE : ST_BADIDX;
            end
            default: begin
               status_in = ST_DONE;
            end
         endcase
         if (ctl.push_front || ctl.push_back) begin
            count_in = count_ff + CNT_W'(1);
         end else if (ctl.pull) begin
            count_in = count_ff - CNT_W'(1);
         end
      end else if (busy_ff) begin
         pos_in = pos_ff + POS_W'(1);
         if (at_end) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         count_ff <= '0;
         pos_ff <= '0;
         status_ff <= ST_DONE;
      end else begin
         busy_ff <= busy_in;
         count_ff <= count_in;
         pos_ff <= pos_in;
         status_ff <= status_in;
      end
   end

   // The chain of cells; the last cell has no right neighbor.
   for (genvar k = 0; k < EFF_CAP; k++) begin : g_cell
      logic [DATA_W-1:0] left_w;
      logic [DATA_W-1:0] right_w;
      if (k == 0) begin : g_first
         assign left_w = cell_values[0];
      end else begin : g_mid
         assign left_w = cell_values[k-1];
      end
      if (k == EFF_CAP - 1) begin : g_tail
         assign right_w = cell_values[k];
      end else begin : g_inner
         assign right_w = cell_values[k+1];
      end
      olht_cell #(
         .INDEX(k)
      ) u_cell (
         .clock(clock),
         .ctl(ctl),
         .word_in(req_value),
         .left_value(left_w),
         .right_value(right_w),
         .head_value(cell_values[0]),
         .value_out(cell_values[k])
      );
   end

   // Result word: the head cell while the chain rotates, zero for an empty list.
   assign busy = busy_ff;
   assign rsp_valid = busy_ff;
   assign rsp_element = list_none ? '0 : cell_values[0];
   assign rsp_position = pos_ff;
   assign rsp_list_empty = list_none;
   assign rsp_status = status_ff;
   assign rsp_last = at_end;

   `OLHT_ASSERT(a_count_cap, clock, reset, count_ff <= CAP_COUNT, "count above capacity")
   `OLHT_ASSERT(a_accept_emits, clock, reset, accept |=> rsp_valid, "no word after command")
   `OLHT_ASSERT(a_last_frees, clock, reset, (rsp_valid && rsp_last) |=> !busy, "busy after last")
   `OLHT_ASSERT_NEVER(a_empty_not_last, clock, reset, rsp_valid && rsp_list_empty && !rsp_last,
      "empty word not last")

endmodule

/* src/olht_cell.sv */
// One storage cell of the list chain, exchanging words with its neighbors.
module olht_cell #(
   parameter int INDEX = 0
) (
   input  logic clock,
   input  olht_pkg::ctl_type ctl,
   input  logic [olht_pkg::DATA_W-1:0] word_in,
   input  logic [olht_pkg::DATA_W-1:0] left_value,
   input  logic [olht_pkg::DATA_W-1:0] right_value,
   input  logic [olht_pkg::DATA_W-1:0] head_value,
   output logic [olht_pkg::DATA_W-1:0] value_out
);
   import olht_pkg::*;

   localparam logic [CNT_W-1:0] MY_POS = CNT_W'(INDEX);
   localparam logic [CNT_W-1:0] MY_NEXT = CNT_W'(INDEX + 1);

   logic [DATA_W-1:0] value_ff;
   logic [DATA_W-1:0] value_in;

   // Select the word this cell takes in this cycle.
   always_comb begin
      value_in = value_ff;
      if (ctl.push_front) begin
         value_in = (INDEX == 0) ? word_in : left_value;
      end else if (ctl.push_back) begin
         if (ctl.count == MY_POS) begin
            value_in = word_in;
         end
      end else if (ctl.pull) begin
         if (MY_POS >= {1'b0, ctl.index}) begin
            value_in = right_value;
         end
      end else if (ctl.rotate) begin
         if (MY_NEXT < ctl.count) begin
            value_in = right_value;
         end else if (MY_NEXT == ctl.count) begin
            value_in = head_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value_out = value_ff;

endmodule
